>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers; the clock is clk_i and the reset is rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/jpdg_pkg.sv
package jpdg_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned THR_BITS      = 34;
  localparam int unsigned HOLD_BITS     = 8;
  localparam int unsigned CFG_DATA_BITS = 34;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
  localparam int unsigned SUM_BITS = SQ_BITS + 2;
  localparam int unsigned CMP_BITS = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 1'd1;

  localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 34'd11341;
  localparam logic [HOLD_BITS-1:0] HOLD_RESET      = 8'd15;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left_hand_x;
    coord_t left_hand_y;
    coord_t left_hand_z;
    coord_t right_hand_x;
    coord_t right_hand_y;
    coord_t right_hand_z;
    coord_t left_elbow_x;
    coord_t left_elbow_y;
    coord_t left_elbow_z;
    coord_t right_elbow_x;
    coord_t right_elbow_y;
    coord_t right_elbow_z;
  } in_item_t;

  typedef struct packed {
    logic fire_next;
    logic fire_previous;
    logic fire_toggle;
    logic repeat_mode_on;
  } out_item_t;

  typedef struct packed {
    logic nxt;
    logic prev;
    logic tog;
  } near_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic pop;
    logic fire_toggle;
    logic mode;
  } back_stat_t;

endpackage

>>> hw/rtl/jpdg_front.sv
module jpdg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  jpdg_pkg::in_item_t                in_data_i,
  input  logic [jpdg_pkg::THR_BITS-1:0]     thr_i,
  input  logic                              full_i,
  output logic                              push_o,
  output jpdg_pkg::near_t                   near_o
);

  localparam int unsigned CW = jpdg_pkg::COORD_BITS;
  localparam int unsigned SW = jpdg_pkg::SQ_BITS;

  function automatic logic [CW-1:0] abs_diff(jpdg_pkg::coord_t a, jpdg_pkg::coord_t b);
    logic signed [CW:0] d;
    logic signed [CW:0] m;
    d = {a[CW-1], a} - {b[CW-1], b};
    m = d[CW] ? -d : d;
    return m[CW-1:0];
  endfunction

  jpdg_pkg::coord_t pa [3][3];
  jpdg_pkg::coord_t pb [3][3];
  logic [CW-1:0]    mag [3][3];
  logic [SW-1:0]    sq_d [3][3];
  logic [SW-1:0]    sq_q [3][3];
  logic             vld_d, vld_q;
  logic             advance;
  logic [jpdg_pkg::SUM_BITS-1:0] sum [3];
  logic [2:0]       near_vec;

  always_comb begin
    pa[0][0] = in_data_i.left_hand_x;   pb[0][0] = in_data_i.right_elbow_x;
    pa[0][1] = in_data_i.left_hand_y;   pb[0][1] = in_data_i.right_elbow_y;
    pa[0][2] = in_data_i.left_hand_z;   pb[0][2] = in_data_i.right_elbow_z;
    pa[1][0] = in_data_i.right_hand_x;  pb[1][0] = in_data_i.left_elbow_x;
    pa[1][1] = in_data_i.right_hand_y;  pb[1][1] = in_data_i.left_elbow_y;
    pa[1][2] = in_data_i.right_hand_z;  pb[1][2] = in_data_i.left_elbow_z;
    pa[2][0] = in_data_i.left_hand_x;   pb[2][0] = in_data_i.right_hand_x;
    pa[2][1] = in_data_i.left_hand_y;   pb[2][1] = in_data_i.right_hand_y;
    pa[2][2] = in_data_i.left_hand_z;   pb[2][2] = in_data_i.right_hand_z;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        mag[p][k]  = abs_diff(pa[p][k], pb[p][k]);
        sq_d[p][k] = mag[p][k] * mag[p][k];
      end
    end
  end

  assign advance    = !vld_q || !full_i;
  assign in_ready_o = advance;
  assign vld_d      = advance ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && advance) begin
      sq_q <= sq_d;
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      sum[p] = jpdg_pkg::SUM_BITS'(sq_q[p][0]) + jpdg_pkg::SUM_BITS'(sq_q[p][1])
             + jpdg_pkg::SUM_BITS'(sq_q[p][2]);
      near_vec[p] = jpdg_pkg::CMP_BITS'(sum[p]) < jpdg_pkg::CMP_BITS'(thr_i);
    end
  end

  assign push_o      = vld_q && !full_i;
  assign near_o.nxt  = near_vec[0];
  assign near_o.prev = near_vec[1];
  assign near_o.tog  = near_vec[2];

endmodule

>>> hw/rtl/jpdg_fifo.sv
module jpdg_fifo #(
  parameter int unsigned Depth = jpdg_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  jpdg_pkg::near_t        data_i,
  input  logic                   pop_i,
  output jpdg_pkg::near_t        data_o,
  output jpdg_pkg::fifo_stat_t   stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  jpdg_pkg::near_t mem_q [Depth];
  logic [PtrW-1:0] wr_d, wr_q, rd_d, rd_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> hw/rtl/jpdg_back.sv
module jpdg_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  jpdg_pkg::near_t                near_i,
  input  logic [jpdg_pkg::HOLD_BITS-1:0] hold_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output jpdg_pkg::out_item_t            out_data_o,
  output jpdg_pkg::back_stat_t           stat_o
);

  localparam int unsigned HW = jpdg_pkg::HOLD_BITS;

  logic [HW-1:0] nxt_d, nxt_q, prev_d, prev_q, tog_d, tog_q;
  logic          mode_d, mode_q;
  logic          fn, fp, ft;
  logic          pop;
  logic          out_valid_d, out_valid_q;
  jpdg_pkg::out_item_t out_d, out_q;

  assign pop = !empty_i && (!out_valid_q || out_ready_i);

  // Pairs are applied in order: next, previous, toggle.
  always_comb begin
    nxt_d  = nxt_q;
    prev_d = prev_q;
    tog_d  = tog_q;
    fn     = 1'b0;
    fp     = 1'b0;
    ft     = 1'b0;
    if (near_i.nxt) begin
      nxt_d  = nxt_d + HW'(1);
      prev_d = '0;
      tog_d  = '0;
      if (nxt_d == hold_i) begin
        nxt_d = '0;
        fn    = 1'b1;
      end
    end
    if (near_i.prev) begin
      prev_d = prev_d + HW'(1);
      nxt_d  = '0;
      tog_d  = '0;
      if (prev_d == hold_i) begin
        prev_d = '0;
        fp     = 1'b1;
      end
    end
    if (near_i.tog) begin
      tog_d  = tog_d + HW'(1);
      nxt_d  = '0;
      prev_d = '0;
      if (tog_d == hold_i) begin
        tog_d = '0;
        ft    = 1'b1;
      end
    end
    mode_d               = mode_q ^ ft;
    out_d.fire_next      = fn;
    out_d.fire_previous  = fp;
    out_d.fire_toggle    = ft;
    out_d.repeat_mode_on = mode_d;
  end

  assign out_valid_d = pop ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_q       <= '0;
      prev_q      <= '0;
      tog_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        nxt_q  <= nxt_d;
        prev_q <= prev_d;
        tog_q  <= tog_d;
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign pop_o              = pop;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign stat_o.pop         = pop;
  assign stat_o.fire_toggle = ft;
  assign stat_o.mode        = mode_q;

endmodule

>>> hw/rtl/joint_proximity_dwell_gesture_unit.sv
// Path: the input frame is registered in the squaring stage (sq_q), queued in the FIFO,
// and registered again in the output register (out_q) before out_valid_o rises.
// Throughput: one frame per cycle unless the queue is full or the output stalls:
// the registered squaring stage and the per-frame counter update each take one frame.
// Reset (async, active low) clears the hold counters, the mode flag and the queue,
// and returns the threshold to 11341 and the hold length to 15.
`include "assert_macros.svh"

module joint_proximity_dwell_gesture_unit #(
  parameter int unsigned QueueDepth = jpdg_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  jpdg_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output jpdg_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [jpdg_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [jpdg_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [jpdg_pkg::THR_BITS-1:0]  thr_d, thr_q;
  logic [jpdg_pkg::HOLD_BITS-1:0] hold_d, hold_q;
  logic                 push, pop;
  jpdg_pkg::near_t      near_in, near_out;
  jpdg_pkg::fifo_stat_t fifo_stat;
  jpdg_pkg::back_stat_t back_stat;

  always_comb begin
    thr_d  = thr_q;
    hold_d = hold_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        jpdg_pkg::CFG_THRESHOLD: thr_d  = cfg_data_i[jpdg_pkg::THR_BITS-1:0];
        jpdg_pkg::CFG_HOLD:      hold_d = cfg_data_i[jpdg_pkg::HOLD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= jpdg_pkg::THRESHOLD_RESET;
      hold_q <= jpdg_pkg::HOLD_RESET;
    end else begin
      thr_q  <= thr_d;
      hold_q <= hold_d;
    end
  end

  jpdg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .thr_i      (thr_q),
    .full_i     (fifo_stat.full),
    .push_o     (push),
    .near_o     (near_in)
  );

  jpdg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (near_in),
    .pop_i  (pop),
    .data_o (near_out),
    .stat_o (fifo_stat)
  );

  jpdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_stat.empty),
    .near_i      (near_out),
    .hold_i      (hold_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (back_stat)
  );

  `ASSERT_IMPL(a_push_not_full, push, !fifo_stat.full, "push into full queue")
  `ASSERT_IMPL(a_pop_not_empty, back_stat.pop, !fifo_stat.empty, "pop from empty queue")
  `ASSERT_NEXT(a_toggle_flips_mode, back_stat.pop && back_stat.fire_toggle, !$stable(back_stat.mode), "toggle fire did not flip mode")
  `ASSERT_IMPL(a_mode_change_cause, !$stable(back_stat.mode), $past(back_stat.pop && back_stat.fire_toggle), "mode changed without toggle fire")
  `ASSERT_IMPL(a_out_valid_source, $rose(out_valid_o), $past(back_stat.pop), "result valid without queue pop")

endmodule
